// ----- rtl/core/tcw_pkg.sv -----
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = COLUMNS * ROWS;
    // Cells below the bottom row's base are copied during a scroll.
    localparam int COPY_COUNT  = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);

    // Field widths.
    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 16;

    localparam logic [CHAR_W-1:0] ATTR_NORMAL  = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT_CURSOR = 2'd0,
        FN_PUT_POS    = 2'd1,
        FN_CLEAR      = 2'd2,
        FN_READ       = 2'd3
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic take_item;
        logic exec;
        logic sweep;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic need_sweep;
        logic sweep_last;
    } t_dp_status;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

endpackage

// ----- rtl/core/tcw_datapath.sv -----
module tcw_datapath import tcw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_item   i_item,
    output t_dp_status o_status,
    output t_out_item  o_result
);

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;

    t_in_item          r_item;
    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic              r_scrolled;
    logic              r_rd_hit;
    logic [ADDR_W-1:0] r_idx;
    logic              r_mode_blank;
    logic              r_pend_valid;
    logic [ADDR_W-1:0] r_pend_addr;
    logic              r_pend_blank;
    t_out_item         r_out;

    // Item evaluation, used in the execute cycle.
    logic [COL_W:0]    x_col;
    logic [ROW_W:0]    x_row;
    logic              x_we;
    logic [ADDR_W-1:0] x_addr;
    logic [CELL_W-1:0] x_wdata;
    logic              x_re;
    logic              x_clear;
    logic              x_scroll;
    logic              x_on_screen;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              sweep_copy;

    always_comb begin
        x_col       = {1'b0, r_cur_col};
        x_row       = {1'b0, r_cur_row};
        x_we        = 1'b0;
        x_addr      = cell_addr(r_cur_row, r_cur_col);
        x_wdata     = BLANK_CELL;
        x_re        = 1'b0;
        x_clear     = 1'b0;
        x_scroll    = 1'b0;
        x_on_screen = ({1'b0, r_item.col} < (COL_W+1)'(COLUMNS))
                   && ({1'b0, r_item.row} < (ROW_W+1)'(ROWS));
        case (t_func'(r_item.func))
            FN_PUT_CURSOR: begin
                if (r_item.char_code == CH_NEWLINE) begin
                    x_col = '0;
                    x_row = x_row + 1'b1;
                end else if (r_item.char_code == CH_BACKSPACE) begin
                    if (r_cur_col != '0) begin
                        x_col = x_col - 1'b1;
                    end else if (r_cur_row != '0) begin
                        x_row = x_row - 1'b1;
                        x_col = (COL_W+1)'(COLUMNS - 1);
                    end
                    x_we    = 1'b1;
                    x_addr  = cell_addr(x_row[ROW_W-1:0], x_col[COL_W-1:0]);
                    x_wdata = BLANK_CELL;
                end else begin
                    x_we    = 1'b1;
                    x_wdata = {ATTR_NORMAL, r_item.char_code};
                    x_col   = x_col + 1'b1;
                end
                if (x_col >= (COL_W+1)'(COLUMNS)) begin
                    x_col = '0;
                    x_row = x_row + 1'b1;
                end
                if (x_row >= (ROW_W+1)'(ROWS)) begin
                    x_scroll = 1'b1;
                    x_row    = (ROW_W+1)'(ROWS - 1);
                end
            end
            FN_PUT_POS: begin
                x_we    = x_on_screen;
                x_addr  = cell_addr(r_item.row, r_item.col);
                x_wdata = {ATTR_NORMAL, r_item.char_code};
            end
            FN_CLEAR: begin
                x_clear = 1'b1;
                x_col   = '0;
                x_row   = '0;
            end
            FN_READ: begin
                x_re   = x_on_screen;
                x_addr = cell_addr(r_item.row, r_item.col);
            end
            default: begin
                x_re = 1'b0;
            end
        endcase
    end

    // During a scroll sweep each step reads the cell one row below and the
    // delayed write stage stores it in the next cycle.
    assign sweep_copy = i_cmd.sweep && !r_mode_blank && (r_idx < ADDR_W'(COPY_COUNT));

    always_comb begin
        if (i_cmd.exec) begin
            mem_we    = x_we;
            mem_waddr = x_addr;
            mem_wdata = x_wdata;
            mem_re    = x_re;
            mem_raddr = x_addr;
        end else begin
            mem_we    = r_pend_valid;
            mem_waddr = r_pend_addr;
            mem_wdata = r_pend_blank ? BLANK_CELL : r_rdata;
            mem_re    = sweep_copy;
            mem_raddr = r_idx + ADDR_W'(COLUMNS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_idx        <= '0;
            r_mode_blank <= 1'b1;
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= i_cmd.sweep;
            if (i_cmd.exec) begin
                r_cur_col    <= x_col[COL_W-1:0];
                r_cur_row    <= x_row[ROW_W-1:0];
                r_idx        <= '0;
                r_mode_blank <= x_clear;
            end else if (i_cmd.sweep) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_scrolled <= x_scroll;
            r_rd_hit   <= x_re;
        end
        if (i_cmd.sweep) begin
            r_pend_addr  <= r_idx;
            r_pend_blank <= r_mode_blank || (r_idx >= ADDR_W'(COPY_COUNT));
        end
        if (i_cmd.load_out) begin
            r_out.cursor_col <= r_cur_col;
            r_out.cursor_row <= r_cur_row;
            r_out.cell_data  <= r_rd_hit ? r_rdata : '0;
            r_out.scrolled   <= r_scrolled;
        end
    end

    assign o_status.need_sweep = x_clear || x_scroll;
    assign o_status.sweep_last = (r_idx == ADDR_W'(CELL_COUNT - 1));
    assign o_result            = r_out;

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_col < COL_W'(COLUMNS)) && (r_cur_row < ROW_W'(ROWS)))
        else $error("cursor left the screen");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> !r_pend_valid)
        else $error("sweep write pending during execute cycle");

    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && x_scroll) |=> (r_cur_row == ROW_W'(ROWS - 1)))
        else $error("scroll did not leave cursor on bottom row");

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
module tcw_ctrl import tcw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.need_sweep ? ST_SWEEP : ST_DONE;
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_EXEC))
        else $error("accepted transaction not executed");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && i_status.sweep_last) |=> (r_state == ST_DONE))
        else $error("sweep did not finish into result stage");

endmodule

// ----- rtl/core/text_console_writer_top.sv -----
// Text console writer: an 80 x 25 screen of 16-bit cells (attribute 0x07 in the
// high byte, character in the low byte) with a cursor. Each input transaction
// carries one operation: put a character at the cursor (newline, backspace,
// wrap and one-row scroll included), put a character at a given position
// (positions off the screen are ignored), clear the screen and home the cursor,
// or read one cell. Every input transaction produces exactly one output
// transaction reporting the cursor after the operation, the cell read (zero for
// anything but an on-screen read) and whether the screen scrolled. A plain put
// or read passes from acceptance through an execute state to a done state,
// where its result is loaded into the result register; a clear, or a put that
// scrolls, also walks the whole cell memory one cell a cycle in a sweep state
// between the two, since the single-port-write cell memory is the limit. After
// reset the block blanks the screen and holds o_in_stall high meanwhile. One
// operation is worked on at a time; a finished result sits in the output
// register, so the next transaction is accepted while it waits.
module text_console_writer_top import tcw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // The controller sequences each transaction (execute, optional sweep,
    // result load); the datapath owns the cell memory, cursor and result.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    tcw_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_item   (i_in_data),
        .o_status (dp_status),
        .o_result (o_out_data)
    );

endmodule
